// ===== rtl/lldwd_pkg.sv =====
package lldwd_pkg;

   localparam int MAX_SERVERS = 16;
   localparam int SRV_W       = $clog2(MAX_SERVERS);
   localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
   localparam int CFG_W       = 5;
   localparam int COST_W      = 8;
   localparam int AMT_W       = 8;
   localparam int LOAD_W      = 32;
   localparam int PROD_W      = COST_W + AMT_W;

   localparam logic REQ_SET_COST = 1'b0;
   localparam logic REQ_DISPATCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ADD
   } state_type;

   // search word handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [SRV_W-1:0]  idx;
      logic [LOAD_W-1:0] load;
      logic [COST_W-1:0] cost;
   } token_type;

   // write and clear strobes broadcast to every cell
   typedef struct packed {
      logic              cost_we;
      logic [SRV_W-1:0]  cost_idx;
      logic [COST_W-1:0] cost_data;
      logic              load_we;
      logic [SRV_W-1:0]  load_idx;
      logic [LOAD_W-1:0] load_data;
      logic              clear;
   } cell_ctl_type;

endpackage

// ===== rtl/lldwd_cell.sv =====
module lldwd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lldwd_pkg::SRV_W-1:0] my_index,
   input  logic                        active,
   input  lldwd_pkg::cell_ctl_type     ctl,
   input  lldwd_pkg::token_type        tok_in,
   output lldwd_pkg::token_type        tok_out
);
   import lldwd_pkg::*;

   logic [LOAD_W-1:0] load_ff;
   logic [COST_W-1:0] cost_ff;
   token_type         tok_ff;
   token_type         tok_in_next;
   logic              take;

   // claim the word when active and strictly lighter; ties stay with the lower index
   always_comb begin
      take = tok_in.valid && active && (!tok_in.found || (load_ff < tok_in.load));
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.idx   = my_index;
         tok_in_next.load  = load_ff;
         tok_in_next.cost  = cost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff      <= '0;
         cost_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
         if (ctl.clear) begin
            load_ff <= '0;
         end else if (ctl.load_we && (ctl.load_idx == my_index)) begin
            load_ff <= ctl.load_data;
         end
         if (ctl.cost_we && (ctl.cost_idx == my_index)) begin
            cost_ff <= ctl.cost_data;
         end
      end
      tok_ff.found <= tok_in_next.found;
      tok_ff.idx   <= tok_in_next.idx;
      tok_ff.load  <= tok_in_next.load;
      tok_ff.cost  <= tok_in_next.cost;
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/least_loaded_weighted_dispatch_core.sv =====
// Least-loaded weighted dispatcher. Each server owns one cell in a row of
// MAX_SERVERS cells holding its 8-bit unit cost and 32-bit load. A cost word
// (req_type 0) writes one cell, with no response. A job word (req_type 1)
// sends a search word down the row, one cell per cycle; each active cell
// keeps the word if its load is strictly smaller, so ties go to the lowest
// index. The winner's cost times job size is added to its load, saturating
// at 0xFFFFFFFF with rsp_overflow set, and the response carries the server,
// its new load and the batch makespan. A job with req_last_job set clears
// all loads and the makespan once its response is formed. The search word
// enters the first cell at the accepting edge and walks the rest of the
// row; the multiply step then registers the product and the add step adds
// and writes back. The block returns to idle as the response appears and
// raises req_ready for the next word in that same cycle; it takes no new
// word while a job is in flight, and the search pass through the cell row
// is most of a job's time. The response register lets the next word in
// while a response waits; a job finishing while the previous response is
// still untaken holds in its add step until that response is taken.
// csr_write_data sets the active server count (0 acts as 1, above
// MAX_SERVERS acts as MAX_SERVERS); write it only while the block is idle.
module least_loaded_weighted_dispatch_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [lldwd_pkg::SRV_W-1:0]  req_server_index,
   input  logic [lldwd_pkg::AMT_W-1:0]  req_amount,
   input  logic                         req_last_job,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lldwd_pkg::SRV_W-1:0]  rsp_chosen_server,
   output logic [lldwd_pkg::LOAD_W-1:0] rsp_finish_time,
   output logic [lldwd_pkg::LOAD_W-1:0] rsp_makespan,
   output logic                         rsp_overflow,
   output logic                         rsp_batch_done,
   input  logic                         csr_write_en,
   input  logic [lldwd_pkg::CFG_W-1:0]  csr_write_data
);
   import lldwd_pkg::*;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    active_cfg_ff;
   logic [CNT_W-1:0]    n_eff;
   logic [MAX_SERVERS-1:0] active;

   logic [AMT_W-1:0]    amt_ff, amt_in;
   logic                last_ff, last_in;
   logic [SRV_W-1:0]    sel_idx_ff, sel_idx_in;
   logic [LOAD_W-1:0]   sel_load_ff, sel_load_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [LOAD_W-1:0]   largest_ff, largest_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SRV_W-1:0]    rsp_server_ff, rsp_server_in;
   logic [LOAD_W-1:0]   rsp_finish_ff, rsp_finish_in;
   logic [LOAD_W-1:0]   rsp_span_ff, rsp_span_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [LOAD_W:0]     sum;
   logic                sum_ovf;
   logic [LOAD_W-1:0]   new_load;
   logic [LOAD_W-1:0]   new_largest;

   cell_ctl_type        ctl;
   token_type           tok_head;
   token_type           tok [0:MAX_SERVERS];
   logic                accept;

   // clamp the active count into 1..MAX_SERVERS
   always_comb begin
      if (active_cfg_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (active_cfg_ff > CFG_W'(MAX_SERVERS)) begin
         n_eff = CNT_W'(MAX_SERVERS);
      end else begin
         n_eff = CNT_W'(active_cfg_ff);
      end
      for (int k = 0; k < MAX_SERVERS; k++) begin
         active[k] = (CNT_W'(k) < n_eff);
      end
   end

   // saturating add of the winner's load and its weighted job size
   always_comb begin
      sum         = {1'b0, sel_load_ff} + {{(LOAD_W + 1 - PROD_W){1'b0}}, prod_ff};
      sum_ovf     = sum[LOAD_W];
      new_load    = sum_ovf ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
      new_largest = (new_load > largest_ff) ? new_load : largest_ff;
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      amt_in        = amt_ff;
      last_in       = last_ff;
      sel_idx_in    = sel_idx_ff;
      sel_load_in   = sel_load_ff;
      prod_in       = prod_ff;
      largest_in    = largest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_server_in = rsp_server_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_span_in   = rsp_span_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_done_in   = rsp_done_ff;

      ctl           = '0;
      ctl.cost_idx  = req_server_index;
      ctl.cost_data = req_amount;
      ctl.load_idx  = sel_idx_ff;
      ctl.load_data = new_load;

      tok_head      = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_type == REQ_SET_COST) begin
                  ctl.cost_we = 1'b1;
               end else begin
                  // launch the search word into the first cell
                  tok_head.valid = 1'b1;
                  amt_in         = req_amount;
                  last_in        = req_last_job;
                  state_in       = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (tok[MAX_SERVERS].valid) begin
               sel_idx_in  = tok[MAX_SERVERS].idx;
               sel_load_in = tok[MAX_SERVERS].load;
               prod_in     = PROD_W'(tok[MAX_SERVERS].cost) * PROD_W'(amt_ff);
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            // hold while the previous response still waits
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_server_in = sel_idx_ff;
               rsp_finish_in = new_load;
               rsp_span_in   = new_largest;
               rsp_ovf_in    = sum_ovf;
               rsp_done_in   = last_ff;
               if (last_ff) begin
                  ctl.clear  = 1'b1;
                  largest_in = '0;
               end else begin
                  ctl.load_we = 1'b1;
                  largest_in  = new_largest;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign tok[0] = tok_head;

   for (genvar k = 0; k < MAX_SERVERS; k++) begin : g_cell
      lldwd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_index (SRV_W'(k)),
         .active   (active[k]),
         .ctl      (ctl),
         .tok_in   (tok[k]),
         .tok_out  (tok[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_cfg_ff <= CFG_W'(MAX_SERVERS);
         largest_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            active_cfg_ff <= csr_write_data;
         end
      end
      amt_ff        <= amt_in;
      last_ff       <= last_in;
      sel_idx_ff    <= sel_idx_in;
      sel_load_ff   <= sel_load_in;
      prod_ff       <= prod_in;
      rsp_server_ff <= rsp_server_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_server = rsp_server_ff;
   assign rsp_finish_time   = rsp_finish_ff;
   assign rsp_makespan      = rsp_span_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_batch_done    = rsp_done_ff;

`ifndef SYNTH
   // a new response word only ever comes out of the add step
   a_rsp_from_add: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ADD))
      else $error("response raised outside the add step");

   // the reported load never exceeds the reported makespan
   a_finish_le_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_finish_ff <= rsp_span_ff))
      else $error("finish time above makespan");

   // a saturated add reports the maximum load
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_finish_ff == {LOAD_W{1'b1}}))
      else $error("overflow without saturated load");

   // the search word reaches the row end only while a search is running
   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_SERVERS].valid |-> (state_ff == ST_SEARCH))
      else $error("search word outside search state");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
   import lldwd_pkg::*;

   // Quiet cycles after the last response before a register write or the end
   // of the run: one search pass through the cell row plus a small margin.
   localparam int SETTLE_CYCLES  = MAX_SERVERS + 8;
   // Long response-side hold-off; long enough to back the block up to its input.
   localparam int PARK_CYCLES    = 400;
   // Worst honest quiet stretch is the hold-off plus one job; this is ~10x that.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 150;
   localparam int RANDOM_PHASES  = 12;
   localparam int SWEEP_SIZE     = 10;
   // Heaviest jobs run back to back on one server at the end of the run.
   localparam int FINAL_JOBS     = 40;
   localparam int DIRECTED_ROWS  = 19;

   typedef struct packed {
      logic [SRV_W-1:0]  server;
      logic [LOAD_W-1:0] finish;
      logic [LOAD_W-1:0] span;
      logic              ovf;
      logic              done;
   } job_result_type;

   typedef struct packed {
      logic              kind;
      logic [SRV_W-1:0]  idx;
      logic [AMT_W-1:0]  amt;
      logic              last;
      logic              typed;
      job_result_type    want;
   } stim_row_type;

   // Directed words, run with the reset server count of 16. Rows marked typed
   // carry a response that follows from reset state by hand; the rest go
   // through the load predictor.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // all costs are zero after reset: server 0 wins the tie, load stays 0
      '{REQ_DISPATCH, 4'd0,  8'd255, 1'b0, 1'b1, '{4'd0, 32'd0,   32'd0,   1'b0, 1'b0}},
      // cost word with last_job set: the flag is ignored, no response
      '{REQ_SET_COST, 4'd15, 8'd255, 1'b1, 1'b0, '0},
      '{REQ_SET_COST, 4'd0,  8'd1,   1'b0, 1'b0, '0},
      // zero-size job: still assigned and reported
      '{REQ_DISPATCH, 4'd0,  8'd0,   1'b0, 1'b1, '{4'd0, 32'd0,   32'd0,   1'b0, 1'b0}},
      // server index field is don't-care on a job word
      '{REQ_DISPATCH, 4'd15, 8'd255, 1'b0, 1'b1, '{4'd0, 32'd255, 32'd255, 1'b0, 1'b0}},
      // zero-cost server takes the job, load unchanged
      '{REQ_DISPATCH, 4'd0,  8'd7,   1'b0, 1'b1, '{4'd1, 32'd0,   32'd255, 1'b0, 1'b0}},
      '{REQ_SET_COST, 4'd1,  8'd2,   1'b0, 1'b0, '0},
      '{REQ_DISPATCH, 4'd0,  8'd10,  1'b0, 1'b1, '{4'd1, 32'd20,  32'd255, 1'b0, 1'b0}},
      // end of batch: report first, then clear every load
      '{REQ_DISPATCH, 4'd0,  8'd3,   1'b1, 1'b1, '{4'd2, 32'd0,   32'd255, 1'b0, 1'b1}},
      '{REQ_DISPATCH, 4'd0,  8'd1,   1'b0, 1'b1, '{4'd0, 32'd1,   32'd1,   1'b0, 1'b0}},
      '{REQ_DISPATCH, 4'd0,  8'd255, 1'b0, 1'b1, '{4'd1, 32'd510, 32'd510, 1'b0, 1'b0}},
      '{REQ_DISPATCH, 4'd0,  8'd4,   1'b0, 1'b1, '{4'd2, 32'd0,   32'd510, 1'b0, 1'b0}},
      '{REQ_SET_COST, 4'd3,  8'd128, 1'b0, 1'b0, '0},
      '{REQ_SET_COST, 4'd10, 8'd85,  1'b0, 1'b0, '0},
      '{REQ_SET_COST, 4'd2,  8'd170, 1'b0, 1'b0, '0},
      '{REQ_DISPATCH, 4'd5,  8'd170, 1'b0, 1'b0, '0},
      '{REQ_DISPATCH, 4'd0,  8'd1,   1'b1, 1'b0, '0},
      '{REQ_SET_COST, 4'd15, 8'd0,   1'b0, 1'b0, '0},
      // leave this batch open so the next count change lands mid-batch
      '{REQ_DISPATCH, 4'd0,  8'd255, 1'b0, 1'b0, '0}
   };

   // Server counts for the first SWEEP_SIZE phases: zero acts as one, above 16 clamps to 16.
   localparam logic [CFG_W-1:0] SWEEP [SWEEP_SIZE] = '{
      5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd9, 5'd16, 5'd4, 5'd3, 5'd12
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic              req_type         = REQ_DISPATCH;
   logic [SRV_W-1:0]  req_server_index = '0;
   logic [AMT_W-1:0]  req_amount       = '0;
   logic              req_last_job     = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [SRV_W-1:0]  rsp_chosen_server;
   logic [LOAD_W-1:0] rsp_finish_time;
   logic [LOAD_W-1:0] rsp_makespan;
   logic              rsp_overflow;
   logic              rsp_batch_done;
   logic              csr_write_en     = 1'b0;
   logic [CFG_W-1:0]  csr_write_data   = '0;

   // Shadow of the block: per-server cost and load, batch makespan, count.
   logic [COST_W-1:0] unit_cost   [MAX_SERVERS];
   logic [LOAD_W-1:0] server_load [MAX_SERVERS];
   logic [LOAD_W-1:0] peak_load;
   logic [CFG_W-1:0]  active_cfg;

   job_result_type pending_dispatches [$];

   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;
   bit park_req  = 1'b0;

   int job_words   = 0;
   int cost_words  = 0;
   int checked     = 0;
   int saturated   = 0;
   int batches     = 0;
   int mismatches  = 0;
   int idle_cycles = 0;

   least_loaded_weighted_dispatch_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_server_index  (req_server_index),
      .req_amount        (req_amount),
      .req_last_job      (req_last_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_makespan      (rsp_makespan),
      .rsp_overflow      (rsp_overflow),
      .rsp_batch_done    (rsp_batch_done),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      $display("tb: mismatch: %s", msg);
      mismatches++;
   endtask

   // Greedy pick of the least-loaded active server, ties to the lowest index;
   // grow its load by cost * size with saturation, then track the makespan.
   function automatic job_result_type dispatch_job(input logic [AMT_W-1:0] size,
                                                   input logic last);
      job_result_type    r;
      int                n;
      int                k;
      int                pick;
      logic [PROD_W-1:0] product;
      logic [LOAD_W:0]   grown;
      n = int'(active_cfg);
      if (n == 0)
         n = 1;
      if (n > MAX_SERVERS)
         n = MAX_SERVERS;
      pick = 0;
      for (k = 1; k < n; k++) begin
         if (server_load[k] < server_load[pick])
            pick = k;
      end
      product = PROD_W'(unit_cost[pick]) * PROD_W'(size);
      grown   = (LOAD_W + 1)'(server_load[pick]) + (LOAD_W + 1)'(product);
      r.ovf   = grown[LOAD_W];
      server_load[pick] = grown[LOAD_W] ? '1 : grown[LOAD_W-1:0];
      if (server_load[pick] > peak_load)
         peak_load = server_load[pick];
      r.server = SRV_W'(pick);
      r.finish = server_load[pick];
      r.span   = peak_load;
      r.done   = last;
      // batch end: clear only after the response is formed
      if (last) begin
         foreach (server_load[j])
            server_load[j] = '0;
         peak_load = '0;
      end
      return r;
   endfunction

   // Offer one word, hold it until taken, then update the shadow state.
   // Valid is left high on return so back-to-back words never drop it.
   task automatic send_word(input logic kind, input logic [SRV_W-1:0] idx,
                            input logic [AMT_W-1:0] amt, input logic last,
                            input logic typed, input job_result_type want);
      job_result_type predicted;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_server_index <= idx;
      req_amount       <= amt;
      req_last_job     <= last;
      do @(posedge clock); while (!req_ready);
      if (kind == REQ_SET_COST) begin
         unit_cost[idx] = amt;
         cost_words++;
      end else begin
         predicted = dispatch_job(amt, last);
         pending_dispatches.push_back(typed ? want : predicted);
         job_words++;
      end
   endtask

   // Stop offering and wait for every expected response; optionally let the
   // block run dry afterwards (a trailing cost word gives no response).
   task automatic wait_for_results(input bit settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_dispatches.size() != 0);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      active_cfg = value;
   endtask

   // Mixed cost and job words; roughly one job in twelve closes a batch, so
   // loads build up across many servers before they clear.
   task automatic run_random_phase(input int words, input bit park, input bit pause);
      int               k;
      logic             kind;
      logic [SRV_W-1:0] idx;
      logic [AMT_W-1:0] amt;
      logic             last;
      for (k = 0; k < words; k++) begin
         // back up the block: response side parks while words keep coming
         if (park && k == words / 3)
            park_req = 1'b1;
         // drain fully mid-phase, then resume with the batch still open
         if (pause && k == words / 2)
            wait_for_results(1'b0);
         kind = ($urandom_range(0, 3) == 0) ? REQ_SET_COST : REQ_DISPATCH;
         idx  = SRV_W'($urandom_range(0, MAX_SERVERS - 1));
         case ($urandom_range(0, 7))
            0:       amt = '0;
            1:       amt = '1;
            default: amt = AMT_W'($urandom_range(0, 255));
         endcase
         last = ($urandom_range(0, 11) == 0);
         send_word(kind, idx, amt, last, 1'b0, '0);
      end
   endtask

   // Response side: random stall bursts, plus one long park on request.
   initial begin : response_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0) begin
            if (park_req) begin
               hold_left = PARK_CYCLES;
               park_req  = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
               hold_left = $urandom_range(1, 4);
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each taken response with the oldest expected one.
   always @(posedge clock) begin : check_responses
      job_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dispatches.size() == 0) begin
            report_mismatch($sformatf("response (server %0d) with no job pending",
                                      rsp_chosen_server));
         end else begin
            want = pending_dispatches.pop_front();
            checked++;
            if (want.ovf)
               saturated++;
            if (want.done)
               batches++;
            if (rsp_chosen_server !== want.server)
               report_mismatch($sformatf("chosen_server got %0d expected %0d",
                                         rsp_chosen_server, want.server));
            if (rsp_finish_time !== want.finish)
               report_mismatch($sformatf("finish_time got %0d expected %0d",
                                         rsp_finish_time, want.finish));
            if (rsp_makespan !== want.span)
               report_mismatch($sformatf("makespan got %0d expected %0d",
                                         rsp_makespan, want.span));
            if (rsp_overflow !== want.ovf)
               report_mismatch($sformatf("overflow got %0b expected %0b",
                                         rsp_overflow, want.ovf));
            if (rsp_batch_done !== want.done)
               report_mismatch($sformatf("batch_done got %0b expected %0b",
                                         rsp_batch_done, want.done));
         end
      end
   end

   // Count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      // mirror the reset state of the block
      foreach (unit_cost[j]) begin
         unit_cost[j]   = '0;
         server_load[j] = '0;
      end
      peak_load  = '0;
      active_cfg = CFG_W'(MAX_SERVERS);

      do @(posedge clock); while (reset);

      for (p = 0; p < DIRECTED_ROWS; p++)
         send_word(DIRECTED[p].kind, DIRECTED[p].idx, DIRECTED[p].amt,
                   DIRECTED[p].last, DIRECTED[p].typed, DIRECTED[p].want);

      // Sweep the server count; batches stay open across phases, so lowering
      // the count strands loads that still weigh in the makespan.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_results(1'b1);
         write_active(p < SWEEP_SIZE ? SWEEP[p] : CFG_W'($urandom_range(0, 31)));
         gaps_on   = (p != 8);
         stalls_on = (p != 8);
         run_random_phase(PHASE_WORDS, p == 3, p == 6);
      end

      // Final stretch, no idling: one server takes a run of the heaviest jobs.
      wait_for_results(1'b1);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_active(5'd1);
      send_word(REQ_SET_COST, '0, '1, 1'b0, 1'b0, '0);
      // close whatever batch is open so the climb starts from zero
      send_word(REQ_DISPATCH, '0, '0, 1'b1, 1'b0, '0);
      for (p = 0; p < FINAL_JOBS; p++)
         send_word(REQ_DISPATCH, SRV_W'($urandom_range(0, MAX_SERVERS - 1)), '1,
                   1'b0, 1'b0, '0);
      // zero-size job on a loaded server: load and makespan unchanged
      send_word(REQ_DISPATCH, '1, '0, 1'b0, 1'b0, '0);
      send_word(REQ_DISPATCH, '1, 8'd1, 1'b1, 1'b0, '0);
      send_word(REQ_DISPATCH, '0, '1, 1'b0, 1'b0, '0);
      wait_for_results(1'b1);

      $display("tb: %0d job words and %0d cost words over %0d server-count settings",
               job_words, cost_words, RANDOM_PHASES + 2);
      $display("tb: %0d responses checked, %0d batches closed, %0d saturating jobs",
               checked, batches, saturated);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
